// ===== hw/rtl/ztest_blend_pixel_unit_top_macros.svh =====
// Assertion macros for the z-tested blend pixel unit.
// Used by ztest_blend_pixel_unit_top; expects clk and rst_n in scope.
`ifndef ZTEST_BLEND_PIXEL_UNIT_TOP_MACROS_SVH
`define ZTEST_BLEND_PIXEL_UNIT_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ZTBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ZTBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ztbp_pkg.sv =====
// Shared types and constants for the z-tested blend pixel unit.
// No dependencies.
`default_nettype none

package ztbp_pkg;

  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned ZFIX_W    = 32;
  localparam int unsigned TERM_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [CH_W-1:0] ALPHA_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_CH0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_CH1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_CH2   = 3'd4;

  localparam logic [1:0] MODE_OPAQUE = 2'd0;
  localparam logic [1:0] MODE_BLEND  = 2'd1;
  localparam logic [1:0] MODE_CONST  = 2'd2;
  localparam logic [1:0] MODE_ALPHA  = 2'd3;

  typedef enum logic [1:0] {
    OP_KEEP  = 2'd0,
    OP_COPY  = 2'd1,
    OP_MIX   = 2'd2,
    OP_CONST = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]                    draw_mode;
    logic [CH_W-1:0]               blend_alpha;
    logic [NUM_CH-1:0][TERM_W-1:0] const_term;
  } cfg_t;

  typedef struct packed {
    op_t                         op;
    logic [CH_W-1:0]             wgt;
    logic [NUM_CH-1:0][CH_W-1:0] dest;
    logic [NUM_CH-1:0][CH_W-1:0] tex;
    logic [DEPTH_W-1:0]          z;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ztest_blend_pixel_unit_top.sv =====
// Z-tested blend pixel unit, top level: config registers, front, queue, back.
// Depends on ztbp_pkg, ztbp_front, ztbp_queue, ztbp_back and the macros header.
//
// Takes one pixel request per clock and returns one result per request, in order.
// The depth test and mode choice (with the alpha-test coverage product) happen on
// entry; a two-entry queue decouples that from the per-channel blend multipliers,
// which feed the output register. out_valid rises once an accepted request has
// passed the queue and the output register; sustained rate is one pixel per
// cycle while out_stall stays low. A stalled output holds its result while the
// queue absorbs up to two more requests before in_stall rises. Configuration
// writes take effect at once and must only be issued while the unit is idle.
`default_nettype none
`include "ztest_blend_pixel_unit_top_macros.svh"

module ztest_blend_pixel_unit_top
  import ztbp_pkg::*;
(
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  cfg_we,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [CFG_DAT_W-1:0]  cfg_wdata,
  input  wire  logic                  in_valid,
  output logic                        in_stall,
  input  wire  logic [ZFIX_W-1:0]     in_depth_fixed,
  input  wire  logic [DEPTH_W-1:0]    in_stored_depth,
  input  wire  logic [CH_W-1:0]       in_dest_ch0,
  input  wire  logic [CH_W-1:0]       in_dest_ch1,
  input  wire  logic [CH_W-1:0]       in_dest_ch2,
  input  wire  logic [CH_W-1:0]       in_texel_b0,
  input  wire  logic [CH_W-1:0]       in_texel_b1,
  input  wire  logic [CH_W-1:0]       in_texel_b2,
  input  wire  logic [CH_W-1:0]       in_texel_alpha,
  output logic                        out_valid,
  input  wire  logic                  out_stall,
  output logic                        out_color_write,
  output logic [CH_W-1:0]             out_ch0,
  output logic [CH_W-1:0]             out_ch1,
  output logic [CH_W-1:0]             out_ch2,
  output logic                        out_depth_write,
  output logic [DEPTH_W-1:0]          out_depth
);

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  q_entry_t  q_wdata, q_rdata;
  logic      q_push, q_pop;
  logic [NUM_CH-1:0][CH_W-1:0] in_dest, in_tex, out_ch;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DRAW_MODE:   cfg_nxt.draw_mode     = cfg_wdata[1:0];
        CFG_BLEND_ALPHA: cfg_nxt.blend_alpha   = cfg_wdata[CH_W-1:0];
        CFG_CONST_CH0:   cfg_nxt.const_term[0] = cfg_wdata[TERM_W-1:0];
        CFG_CONST_CH1:   cfg_nxt.const_term[1] = cfg_wdata[TERM_W-1:0];
        CFG_CONST_CH2:   cfg_nxt.const_term[2] = cfg_wdata[TERM_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{draw_mode: MODE_OPAQUE, blend_alpha: ALPHA_MAX, const_term: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // texel bytes land swizzled: b2 to byte 0, b0 to byte 2
  assign in_dest = {in_dest_ch2, in_dest_ch1, in_dest_ch0};
  assign in_tex  = {in_texel_b0, in_texel_b1, in_texel_b2};

  ztbp_front u_front (
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_depth_fixed  (in_depth_fixed),
    .in_stored_depth (in_stored_depth),
    .in_dest         (in_dest),
    .in_tex          (in_tex),
    .in_texel_alpha  (in_texel_alpha),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  ztbp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  ztbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_status        (q_status),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_color_write (out_color_write),
    .out_ch          (out_ch),
    .out_depth_write (out_depth_write),
    .out_depth       (out_depth)
  );

  assign out_ch0 = out_ch[0];
  assign out_ch1 = out_ch[1];
  assign out_ch2 = out_ch[2];

  `ZTBP_ASSERT_NOW(a_depth_implies_color, out_valid && out_depth_write, out_color_write,
                   "depth write without colour write")
  `ZTBP_ASSERT_NOW(a_no_push_when_full, q_push, !q_status.full, "queue push while full")
  `ZTBP_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_status.empty, "queue pop while empty")
  `ZTBP_ASSERT_NEXT(a_pop_fills_output, q_pop, out_valid, "popped request not presented")

endmodule

`default_nettype wire

// ===== hw/rtl/ztbp_front.sv =====
// Front end: depth test and mode classification of each incoming pixel.
// Depends on ztbp_pkg.
`default_nettype none

module ztbp_front
  import ztbp_pkg::*;
(
  input  wire  cfg_t                cfg,
  input  wire  logic                in_valid,
  output logic                      in_stall,
  input  wire  logic [ZFIX_W-1:0]   in_depth_fixed,
  input  wire  logic [DEPTH_W-1:0]  in_stored_depth,
  input  wire  logic [NUM_CH-1:0][CH_W-1:0] in_dest,
  input  wire  logic [NUM_CH-1:0][CH_W-1:0] in_tex,
  input  wire  logic [CH_W-1:0]     in_texel_alpha,
  input  wire  q_status_t           q_status,
  output logic                      q_push,
  output q_entry_t                  q_wdata
);

  logic [DEPTH_W-1:0]  z;
  logic                pass;
  logic [2*CH_W-1:0]   alpha_prod;
  logic [CH_W-1:0]     local_alpha;

  assign z           = in_depth_fixed[ZFIX_W-1 -: DEPTH_W];
  assign pass        = $signed(in_stored_depth) <= $signed(z);
  assign alpha_prod  = in_texel_alpha * cfg.blend_alpha;
  assign local_alpha = alpha_prod[2*CH_W-1 -: CH_W];

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_wdata      = '0;
    q_wdata.dest = in_dest;
    q_wdata.tex  = in_tex;
    q_wdata.z    = z;
    q_wdata.op   = OP_KEEP;
    q_wdata.wgt  = cfg.blend_alpha;
    if (pass) begin
      case (cfg.draw_mode)
        MODE_OPAQUE: q_wdata.op = OP_COPY;
        MODE_BLEND:  q_wdata.op = OP_MIX;
        MODE_CONST:  q_wdata.op = OP_CONST;
        MODE_ALPHA: begin
          // zero coverage leaves the pixel untouched
          if (in_texel_alpha != '0) begin
            q_wdata.op  = OP_MIX;
            q_wdata.wgt = local_alpha;
          end
        end
        default: q_wdata.op = OP_KEEP;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ztbp_queue.sv =====
// Short request queue between front and back ends.
// Depends on ztbp_pkg.
`default_nettype none

module ztbp_queue
  import ztbp_pkg::*;
(
  input  wire  logic  clk,
  input  wire  logic  rst_n,
  input  wire  logic  push,
  input  wire  q_entry_t wdata,
  input  wire  logic  pop,
  output q_entry_t    rdata,
  output q_status_t   status
);

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign status.full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign status.empty = cnt_r == '0;
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ztbp_back.sv =====
// Back end: per-channel weighted mix and the output register.
// Depends on ztbp_pkg.
`default_nettype none

module ztbp_back
  import ztbp_pkg::*;
(
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  cfg_t                cfg,
  input  wire  q_status_t           q_status,
  input  wire  q_entry_t            q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire  logic                out_stall,
  output logic                      out_color_write,
  output logic [NUM_CH-1:0][CH_W-1:0] out_ch,
  output logic                      out_depth_write,
  output logic [DEPTH_W-1:0]        out_depth
);

  logic [CH_W-1:0]     inv_wgt;
  logic [2*CH_W-1:0]   mul_d [NUM_CH];
  logic [2*CH_W-1:0]   mul_t [NUM_CH];
  logic [2*CH_W-1:0]   addend [NUM_CH];
  logic [2*CH_W:0]     sum [NUM_CH];
  logic [NUM_CH-1:0][CH_W-1:0] ch_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        color_write_r;
  logic                        depth_write_r;
  logic [NUM_CH-1:0][CH_W-1:0] ch_r;
  logic [DEPTH_W-1:0]          depth_r;

  assign q_pop         = !q_status.empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_pop || (out_valid_r && out_stall);
  assign inv_wgt       = ALPHA_MAX - q_rdata.wgt;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      mul_d[i]  = q_rdata.dest[i] * inv_wgt;
      mul_t[i]  = q_rdata.tex[i] * q_rdata.wgt;
      addend[i] = (q_rdata.op == OP_CONST) ? cfg.const_term[i] : mul_t[i];
      sum[i]    = {1'b0, mul_d[i]} + {1'b0, addend[i]};
      case (q_rdata.op)
        OP_COPY:  ch_nxt[i] = q_rdata.tex[i];
        OP_MIX:   ch_nxt[i] = sum[i][2*CH_W-1 -: CH_W];
        OP_CONST: ch_nxt[i] = sum[i][2*CH_W-1 -: CH_W];
        default:  ch_nxt[i] = q_rdata.dest[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      color_write_r <= q_rdata.op != OP_KEEP;
      depth_write_r <= q_rdata.op == OP_COPY;
      ch_r          <= ch_nxt;
      depth_r       <= q_rdata.z;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_write = color_write_r;
  assign out_depth_write = depth_write_r;
  assign out_ch          = ch_r;
  assign out_depth       = depth_r;

endmodule

`default_nettype wire

// ===== tb/tb_ztest_blend_pixel_unit_top.sv =====
// Testbench for ztest_blend_pixel_unit_top: depth test and four blend modes per pixel.
// Needs ztbp_pkg and the RTL. A built-in predictor is checked against every result,
// under random idling on both channels and several register settings.
`timescale 1ns / 100ps

module tb_ztest_blend_pixel_unit_top;
  import ztbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF_LEN   = 80;
  localparam int HOLD_OFF_AT    = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 54;
  localparam int PRINT_CAP      = 40;

  typedef struct {
    logic [ZFIX_W-1:0]           depth_fixed;
    logic [DEPTH_W-1:0]          stored_depth;
    logic [NUM_CH-1:0][CH_W-1:0] dest;
    logic [NUM_CH-1:0][CH_W-1:0] tex;   // index = texel byte number
    logic [CH_W-1:0]             tex_alpha;
  } pixel_req_t;

  typedef struct {
    logic                        color_write;
    logic [NUM_CH-1:0][CH_W-1:0] ch;
    logic                        depth_write;
    logic [DEPTH_W-1:0]          depth;
  } rop_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ZFIX_W-1:0]    in_depth_fixed = '0;
  logic [DEPTH_W-1:0]   in_stored_depth = '0;
  logic [CH_W-1:0]      in_dest_ch0 = '0, in_dest_ch1 = '0, in_dest_ch2 = '0;
  logic [CH_W-1:0]      in_texel_b0 = '0, in_texel_b1 = '0, in_texel_b2 = '0;
  logic [CH_W-1:0]      in_texel_alpha = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_color_write;
  logic [CH_W-1:0]      out_ch0, out_ch1, out_ch2;
  logic                 out_depth_write;
  logic [DEPTH_W-1:0]   out_depth;

  ztest_blend_pixel_unit_top dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_depth_fixed, .in_stored_depth,
    .in_dest_ch0, .in_dest_ch1, .in_dest_ch2,
    .in_texel_b0, .in_texel_b1, .in_texel_b2, .in_texel_alpha,
    .out_valid, .out_stall, .out_color_write, .out_ch0, .out_ch1, .out_ch2,
    .out_depth_write, .out_depth
  );

  // register copies
  logic [1:0]                    draw_mode_q;
  logic [CH_W-1:0]               blend_alpha_q;
  logic [NUM_CH-1:0][TERM_W-1:0] const_term_q;

  pixel_req_t  pending_pixels[$];
  rop_result_t expected_results[$];
  int          n_queued = 0;
  int          n_accepted = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic        taken_q = 1'b0;
  bit          no_idle = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic rop_result_t rop_predict(pixel_req_t p);
    rop_result_t                 r;
    logic signed [DEPTH_W-1:0]   z;
    logic [NUM_CH-1:0][CH_W-1:0] sw;
    int unsigned                 a, inv, la, linv;
    int                          i;
    z   = p.depth_fixed[ZFIX_W-1 -: DEPTH_W];
    sw  = {p.tex[0], p.tex[1], p.tex[2]};
    a   = 32'(blend_alpha_q);
    inv = ALPHA_MAX - a;
    r.color_write = 1'b0;
    r.depth_write = 1'b0;
    r.ch          = p.dest;
    r.depth       = z;
    if ($signed(p.stored_depth) <= z) begin
      case (draw_mode_q)
        MODE_OPAQUE: begin
          r.ch = sw;
          r.color_write = 1'b1;
          r.depth_write = 1'b1;
        end
        MODE_BLEND: begin
          for (i = 0; i < NUM_CH; i++)
            r.ch[i] = CH_W'((p.dest[i] * inv + sw[i] * a) >> 8);
          r.color_write = 1'b1;
        end
        MODE_CONST: begin
          for (i = 0; i < NUM_CH; i++)
            r.ch[i] = CH_W'((p.dest[i] * inv + const_term_q[i]) >> 8);
          r.color_write = 1'b1;
        end
        default: begin
          if (p.tex_alpha != '0) begin
            la   = (p.tex_alpha * a) >> 8;
            linv = ALPHA_MAX - la;
            for (i = 0; i < NUM_CH; i++)
              r.ch[i] = CH_W'((p.dest[i] * linv + sw[i] * la) >> 8);
            r.color_write = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // sampling side: register copies, request acceptance, result checks, watchdog
  always @(posedge clk) begin
    pixel_req_t  acc;
    rop_result_t got, exp_r;
    int          i;
    bit          moved;
    moved = 1'b0;
    if (!rst_n) begin
      draw_mode_q   <= MODE_OPAQUE;
      blend_alpha_q <= ALPHA_MAX;
      const_term_q  <= '0;
      taken_q       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DRAW_MODE:   draw_mode_q     <= cfg_wdata[1:0];
          CFG_BLEND_ALPHA: blend_alpha_q   <= cfg_wdata[CH_W-1:0];
          CFG_CONST_CH0:   const_term_q[0] <= cfg_wdata;
          CFG_CONST_CH1:   const_term_q[1] <= cfg_wdata;
          CFG_CONST_CH2:   const_term_q[2] <= cfg_wdata;
          default: ;
        endcase
      end
      taken_q <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        acc.depth_fixed  = in_depth_fixed;
        acc.stored_depth = in_stored_depth;
        acc.dest         = {in_dest_ch2, in_dest_ch1, in_dest_ch0};
        acc.tex          = {in_texel_b2, in_texel_b1, in_texel_b0};
        acc.tex_alpha    = in_texel_alpha;
        expected_results.push_back(rop_predict(acc));
        n_accepted++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          exp_r = expected_results.pop_front();
          got.color_write = out_color_write;
          got.ch          = {out_ch2, out_ch1, out_ch0};
          got.depth_write = out_depth_write;
          got.depth       = out_depth;
          if (got.color_write !== exp_r.color_write)
            report_mismatch($sformatf("result %0d color_write: got %0b expected %0b",
                                      results_seen, got.color_write, exp_r.color_write));
          for (i = 0; i < NUM_CH; i++)
            if (got.ch[i] !== exp_r.ch[i])
              report_mismatch($sformatf("result %0d out_ch%0d: got %02h expected %02h",
                                        results_seen, i, got.ch[i], exp_r.ch[i]));
          if (got.depth_write !== exp_r.depth_write)
            report_mismatch($sformatf("result %0d depth_write: got %0b expected %0b",
                                      results_seen, got.depth_write, exp_r.depth_write));
          if (got.depth !== exp_r.depth)
            report_mismatch($sformatf("result %0d out_depth: got %04h expected %04h",
                                      results_seen, got.depth, exp_r.depth));
        end
        results_seen++;
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  // request driver
  int gap_left = 0;
  always @(negedge clk) begin
    pixel_req_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !taken_q)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_pixels.size() > 0) begin
        p = pending_pixels.pop_front();
        in_depth_fixed  <= p.depth_fixed;
        in_stored_depth <= p.stored_depth;
        in_dest_ch0     <= p.dest[0];
        in_dest_ch1     <= p.dest[1];
        in_dest_ch2     <= p.dest[2];
        in_texel_b0     <= p.tex[0];
        in_texel_b1     <= p.tex[1];
        in_texel_b2     <= p.tex[2];
        in_texel_alpha  <= p.tex_alpha;
        in_valid        <= 1'b1;
        gap_left = no_idle ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with one long hold-off so the queue fills and in_stall rises
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_OFF_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_LEN - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!no_idle && $urandom_range(0, 99) < 15) begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic pixel_req_t mk_pixel(logic [ZFIX_W-1:0] zf, logic [DEPTH_W-1:0] sd,
                                          logic [23:0] dest, logic [23:0] tex,
                                          logic [CH_W-1:0] ta);
    pixel_req_t p;
    p.depth_fixed  = zf;
    p.stored_depth = sd;
    p.dest         = dest;
    p.tex          = tex;
    p.tex_alpha    = ta;
    return p;
  endfunction

  function automatic pixel_req_t rand_pixel();
    pixel_req_t         p;
    logic [DEPTH_W-1:0] z;
    int                 r;
    p.stored_depth = DEPTH_W'($urandom);
    // mostly straddle the depth compare so both outcomes occur
    if ($urandom_range(0, 9) < 6) begin
      z = p.stored_depth + DEPTH_W'($urandom_range(0, 4)) - DEPTH_W'(2);
      p.depth_fixed = {z, 16'($urandom)};
    end else begin
      p.depth_fixed = $urandom;
    end
    p.dest = 24'($urandom);
    p.tex  = 24'($urandom);
    r = $urandom_range(0, 9);
    p.tex_alpha = (r == 0) ? 8'h00 : (r == 1) ? ALPHA_MAX : 8'($urandom);
    return p;
  endfunction

  task automatic queue_pixel(pixel_req_t p);
    pending_pixels.push_back(p);
    n_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_term();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'd65025;
      2:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int ph, k;
    logic [CFG_DAT_W-1:0] a;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: opaque copy, depth compare corners
    queue_pixel(mk_pixel(32'h7FFF_FFFF, 16'h7FFF, 24'h000000, 24'hFFFFFF, 8'hFF));
    queue_pixel(mk_pixel(32'h8000_0000, 16'h8000, 24'hFFFFFF, 24'h000000, 8'h00));
    queue_pixel(mk_pixel(32'h8000_0000, 16'h8001, 24'h123456, 24'hABCDEF, 8'h80));
    queue_pixel(mk_pixel(32'hFFFF_FFFF, 16'h0000, 24'hA5A5A5, 24'h5A5A5A, 8'h01));
    queue_pixel(mk_pixel(32'h0000_FFFF, 16'h0000, 24'h010203, 24'hC0FFEE, 8'h7F));
    queue_pixel(mk_pixel(32'h0001_0000, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF));
    wait_idle();

    write_reg(CFG_DRAW_MODE, {14'd0, MODE_BLEND});
    write_reg(CFG_BLEND_ALPHA, 16'd0);
    queue_pixel(mk_pixel(32'h0010_0000, 16'h0000, 24'hFFFFFF, 24'h000000, 8'hFF));
    queue_pixel(mk_pixel(32'h0010_0000, 16'h0010, 24'h80FF01, 24'hFFFFFF, 8'h00));
    wait_idle();
    write_reg(CFG_BLEND_ALPHA, {8'd0, ALPHA_MAX});
    queue_pixel(mk_pixel(32'h0010_0000, 16'h0000, 24'hFFFFFF, 24'hFF00FF, 8'hFF));
    wait_idle();
    write_reg(CFG_BLEND_ALPHA, 16'd128);
    queue_pixel(mk_pixel(32'h0010_0000, 16'h8000, 24'h40C0FF, 24'hFF8000, 8'h10));
    queue_pixel(mk_pixel(32'h0010_0000, 16'h0011, 24'h40C0FF, 24'hFF8000, 8'h10));
    wait_idle();

    // constant colour with a term large enough to wrap the byte
    write_reg(CFG_DRAW_MODE, {14'd0, MODE_CONST});
    write_reg(CFG_BLEND_ALPHA, 16'd0);
    write_reg(CFG_CONST_CH0, 16'd65025);
    write_reg(CFG_CONST_CH1, 16'hFFFF);
    write_reg(CFG_CONST_CH2, 16'd0);
    queue_pixel(mk_pixel(32'h0000_0000, 16'h0000, 24'hFFFFFF, 24'h123456, 8'h00));
    queue_pixel(mk_pixel(32'h7FFF_0000, 16'h8000, 24'h000000, 24'hFFFFFF, 8'hFF));
    wait_idle();

    // alpha-tested: zero coverage, full coverage, minimal coverage, depth fail
    write_reg(CFG_DRAW_MODE, {14'd0, MODE_ALPHA});
    write_reg(CFG_BLEND_ALPHA, {8'd0, ALPHA_MAX});
    queue_pixel(mk_pixel(32'h0100_0000, 16'h0000, 24'h336699, 24'hFFFFFF, 8'h00));
    queue_pixel(mk_pixel(32'h0100_0000, 16'h0000, 24'h336699, 24'hFFFFFF, 8'hFF));
    queue_pixel(mk_pixel(32'h0100_0000, 16'h0000, 24'h336699, 24'hFFFFFF, 8'h01));
    queue_pixel(mk_pixel(32'h0100_0000, 16'h0101, 24'h336699, 24'hFFFFFF, 8'hFF));
    wait_idle();

    // index past the register file must leave every setting alone
    write_reg(CFG_CONST_CH2 + CFG_IDX_W'(1) + CFG_IDX_W'($urandom_range(0, 2)), 16'h0001);
    queue_pixel(mk_pixel(32'h0100_0000, 16'h0000, 24'h336699, 24'hFFFFFF, 8'h80));
    wait_idle();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      // upper data bits are junk for the narrow registers
      write_reg(CFG_DRAW_MODE, {14'($urandom), 2'(ph)});
      case ($urandom_range(0, 3))
        0:       a = {8'($urandom), 8'd0};
        1:       a = {8'($urandom), ALPHA_MAX};
        default: a = 16'($urandom);
      endcase
      write_reg(CFG_BLEND_ALPHA, a);
      write_reg(CFG_CONST_CH0, pick_term());
      write_reg(CFG_CONST_CH1, pick_term());
      write_reg(CFG_CONST_CH2, pick_term());
      no_idle = (ph % 4 == 3);
      for (k = 0; k < PHASE_ITEMS; k++)
        queue_pixel(rand_pixel());
      wait_idle();
      no_idle = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
